// File: rtl/rlra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlra_pkg
// Shared types and constants for the run-length random access block.
// ----------------------------------------------------------------------------
package rlra_pkg;

   localparam int RLRA_MAX_RUNS      = 1024;
   localparam int RLRA_POSITION_WIDTH = 16;
   localparam int RLRA_DATA_WIDTH    = 64;
   localparam int RLRA_SLOT_WIDTH    = 10;
   localparam int RLRA_RUNS_WIDTH    = 11;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic                           req_type;
      logic [RLRA_SLOT_WIDTH-1:0]     run_slot;
      logic [RLRA_POSITION_WIDTH-1:0] run_end;
      logic [RLRA_DATA_WIDTH-1:0]     run_data;
      logic                           run_null;
      logic [RLRA_POSITION_WIDTH-1:0] position;
   } rlra_req_type;

   typedef struct packed {
      logic [RLRA_DATA_WIDTH-1:0] found_data;
      logic                       found_null;
      logic [RLRA_SLOT_WIDTH-1:0] found_run;
      logic                       out_of_range;
   } rlra_rsp_type;

   typedef struct packed {
      logic [RLRA_POSITION_WIDTH-1:0] run_end;
      logic [RLRA_DATA_WIDTH-1:0]     run_data;
      logic                           run_null;
   } rlra_row_type;

   typedef struct packed {
      logic write;
      logic start;
      logic issue_first;
      logic probe;
      logic rsp_load;
   } rlra_cmd_type;

   typedef struct packed {
      logic count_zero;
   } rlra_status_type;

endpackage
`default_nettype wire

// File: rtl/rlra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlra_ctrl
// Sequencer for table writes and binary-search lookups; owns the handshakes.
// ----------------------------------------------------------------------------
module rlra_ctrl
   import rlra_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_kind,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rlra_cmd_type         cmd,
   input  wire rlra_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_PROBE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.write       = accept && (req_kind == REQ_WRITE);
      cmd.start       = accept && (req_kind == REQ_LOOKUP);
      cmd.issue_first = (state_ff == ST_ISSUE);
      cmd.probe       = (state_ff == ST_PROBE);
      cmd.rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) state_in = ST_ISSUE;
         end
         ST_ISSUE, ST_PROBE: begin
            state_in = status.count_zero ? ST_DONE : ST_PROBE;
         end
         ST_DONE: begin
            if (cmd.rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rlra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlra_dp
// Run table memory, search registers, run count register and result register.
// ----------------------------------------------------------------------------
module rlra_dp
   import rlra_pkg::*;
#(
   parameter int MAX_RUNS = RLRA_MAX_RUNS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rlra_cmd_type               cmd,
   output rlra_status_type                 status,
   input  wire rlra_req_type               req_data,
   input  wire logic                       csr_write_enable,
   input  wire logic [RLRA_RUNS_WIDTH-1:0] csr_write_data,
   output rlra_rsp_type                    rsp_data
);

   localparam int ADDR_W = $clog2(MAX_RUNS);
   localparam int CNT_W  = $clog2(MAX_RUNS + 1);

   rlra_row_type                   run_mem_ff [MAX_RUNS];
   rlra_row_type                   row_ff;
   logic [RLRA_RUNS_WIDTH-1:0]     runs_in_use_ff;
   logic [CNT_W-1:0]               lo_ff, count_ff, step_ff, n_ff;
   logic [RLRA_POSITION_WIDTH-1:0] pos_ff;
   logic [RLRA_DATA_WIDTH-1:0]     cand_data_ff;
   logic                           cand_null_ff;
   rlra_rsp_type                   rsp_ff;

   logic [CNT_W-1:0]  n_clamp, lo_in, count_in;
   logic [ADDR_W-1:0] rd_addr;
   logic              take_left, issue, slot_ok;
   rlra_rsp_type      rsp_in;

   always_comb begin
      if (32'(runs_in_use_ff) > 32'(MAX_RUNS)) n_clamp = CNT_W'(MAX_RUNS);
      else n_clamp = CNT_W'(runs_in_use_ff);

      take_left = (row_ff.run_end >= pos_ff);
      lo_in     = lo_ff;
      count_in  = count_ff;
      if (cmd.probe) begin
         if (take_left) begin
            count_in = step_ff;
         end else begin
            lo_in    = lo_ff + step_ff + CNT_W'(1);
            count_in = count_ff - step_ff - CNT_W'(1);
         end
      end

      status.count_zero = (count_in == '0);
      issue   = (cmd.issue_first || cmd.probe) && (count_in != '0);
      rd_addr = ADDR_W'(lo_in + (count_in >> 1));
      slot_ok = (32'(req_data.run_slot) < 32'(MAX_RUNS));

      if (lo_ff == n_ff) begin
         rsp_in              = '0;
         rsp_in.out_of_range = 1'b1;
      end else begin
         rsp_in.found_data   = cand_data_ff;
         rsp_in.found_null   = cand_null_ff;
         rsp_in.found_run    = RLRA_SLOT_WIDTH'(lo_ff);
         rsp_in.out_of_range = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && slot_ok) begin
         run_mem_ff[ADDR_W'(req_data.run_slot)] <= '{run_end:  req_data.run_end,
                                                    run_data: req_data.run_data,
                                                    run_null: req_data.run_null};
      end
      if (issue) begin
         row_ff <= run_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_in_use_ff <= '0;
      end else if (csr_write_enable) begin
         runs_in_use_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lo_ff    <= '0;
         count_ff <= n_clamp;
         n_ff     <= n_clamp;
         pos_ff   <= req_data.position;
      end else if (cmd.probe) begin
         lo_ff    <= lo_in;
         count_ff <= count_in;
      end
      if (cmd.probe && take_left) begin
         cand_data_ff <= row_ff.run_data;
         cand_null_ff <= row_ff.run_null;
      end
      if (issue) begin
         step_ff <= count_in >> 1;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/run_length_random_access.sv
`default_nettype none
// Write transaction: no response.
// Lookup: new requests are held off until the response is loaded, after a binary search
//   of up to P = ceil(log2(n+1)) probes for n runs in use (11 for 1024 runs).
// Throughput is set by the single read port of the run table: one probe per cycle.
// Reset clears the sequencer, the response valid and the run count; the run table
// holds no reset and is undefined until written.
// ----------------------------------------------------------------------------
// run_length_random_access
// Run-length column table with binary-search lookup by row position.
// ----------------------------------------------------------------------------
module run_length_random_access
   import rlra_pkg::*;
#(
   parameter int MAX_RUNS = RLRA_MAX_RUNS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire rlra_req_type               req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rlra_rsp_type                    rsp_data,
   input  wire logic                       csr_write_enable,
   input  wire logic [RLRA_RUNS_WIDTH-1:0] csr_write_data
);

   rlra_cmd_type    cmd;
   rlra_status_type status;

   rlra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rlra_dp #(
      .MAX_RUNS (MAX_RUNS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/rlra_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlra_checker
// Port-level checks for run_length_random_access, bound to the top level.
// ----------------------------------------------------------------------------
module rlra_checker
   import rlra_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire rlra_req_type               req_data,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire rlra_rsp_type               rsp_data
);

   logic req_write, req_lookup;

   assign req_write  = req_valid && !req_stall && (req_data.req_type == REQ_WRITE);
   assign req_lookup = req_valid && !req_stall && (req_data.req_type == REQ_LOOKUP);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.found_data == '0 && !rsp_data.found_null && rsp_data.found_run == '0)
      else $error("out-of-range response carries data");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_lookup |=> req_stall)
      else $error("request taken during lookup");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_write && !rsp_valid |=> !rsp_valid)
      else $error("write transaction produced a response");

endmodule

bind run_length_random_access rlra_checker u_checker (.*);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for run_length_random_access. Looks up the empty table, fills the run table, then drives
// directed and random write and lookup transactions under random idling and
// back-pressure on both channels. Every lookup is checked field by field
// against a binary-search predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
module tb;
   import rlra_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE       = 20;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   rlra_req_type               req_data         = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   rlra_rsp_type               rsp_data;
   logic                       csr_write_enable = 1'b0;
   logic [RLRA_RUNS_WIDTH-1:0] csr_write_data   = '0;

   // predictor state
   logic [RLRA_POSITION_WIDTH-1:0] run_end_tbl  [RLRA_MAX_RUNS];
   logic [RLRA_DATA_WIDTH-1:0]     run_data_tbl [RLRA_MAX_RUNS];
   logic                           run_null_tbl [RLRA_MAX_RUNS];
   int unsigned                    run_count = 0;
   rlra_rsp_type                   pending_lookups [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          bursty      = 1'b1;
   int unsigned hold_request = 0;

   run_length_random_access i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic rlra_rsp_type search_runs(input logic [RLRA_POSITION_WIDTH-1:0] pos);
      int unsigned  lo;
      int unsigned  count;
      int unsigned  half;
      rlra_rsp_type res;
      lo    = 0;
      count = run_count;
      while (count > 0) begin
         half = count / 2;
         if (run_end_tbl[lo + half] < pos) begin
            lo    += half + 1;
            count -= half + 1;
         end else begin
            count = half;
         end
      end
      res = '0;
      if (lo >= run_count) begin
         res.out_of_range = 1'b1;
      end else begin
         res.found_data = run_data_tbl[lo];
         res.found_null = run_null_tbl[lo];
         res.found_run  = lo[RLRA_SLOT_WIDTH-1:0];
      end
      return res;
   endfunction

   function automatic void apply_request(input rlra_req_type item);
      if (item.req_type == REQ_WRITE) begin
         run_end_tbl[item.run_slot]  = item.run_end;
         run_data_tbl[item.run_slot] = item.run_data;
         run_null_tbl[item.run_slot] = item.run_null;
      end else begin
         pending_lookups.push_back(search_runs(item.position));
      end
   endfunction

   function automatic rlra_req_type make_write(input int unsigned slot,
                                               input logic [15:0] run_end,
                                               input logic [63:0] data,
                                               input logic null_flag);
      rlra_req_type item;
      item          = '0;
      item.req_type = REQ_WRITE;
      item.run_slot = slot[RLRA_SLOT_WIDTH-1:0];
      item.run_end  = run_end;
      item.run_data = data;
      item.run_null = null_flag;
      item.position = RLRA_POSITION_WIDTH'($urandom);
      return item;
   endfunction

   function automatic rlra_req_type make_lookup(input logic [15:0] pos);
      rlra_req_type item;
      item          = '0;
      item.req_type = REQ_LOOKUP;
      item.run_slot = RLRA_SLOT_WIDTH'($urandom);
      item.run_end  = RLRA_POSITION_WIDTH'($urandom);
      item.run_data = random_word();
      item.run_null = 1'($urandom);
      item.position = pos;
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      rlra_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected transaction", 64'd1, 64'd0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.found_data !== want.found_data)
               report_mismatch("found_data", rsp_data.found_data, want.found_data);
            if (rsp_data.found_null !== want.found_null)
               report_mismatch("found_null", 64'(rsp_data.found_null),
                               64'(want.found_null));
            if (rsp_data.found_run !== want.found_run)
               report_mismatch("found_run", 64'(rsp_data.found_run), 64'(want.found_run));
            if (rsp_data.out_of_range !== want.out_of_range)
               report_mismatch("out_of_range", 64'(rsp_data.out_of_range),
                               64'(want.out_of_range));
         end
      end
   end

   initial begin : rsp_stall_gen
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && bursty && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap() + 1;
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input rlra_req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(item);
      gap = bursty ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic set_run_count(input int unsigned value);
      wait_drain();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[RLRA_RUNS_WIDTH-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      run_count = (value > RLRA_MAX_RUNS) ? RLRA_MAX_RUNS : value;
   endtask

   function automatic logic [15:0] pick_position();
      int unsigned k;
      int          roll;
      roll = $urandom_range(0, 99);
      if (run_count == 0 || roll < 10) return 16'($urandom);
      if (roll < 13) return 16'h0000;
      if (roll < 16) return 16'hFFFF;
      k = $urandom_range(0, run_count - 1);
      if (roll < 50) return run_end_tbl[k];
      if (roll < 75) return run_end_tbl[k] + 16'd1;
      return run_end_tbl[k] - 16'd1;
   endfunction

   task automatic test_empty_table();
      send_item(make_lookup(16'h0000));
      send_item(make_lookup(16'hFFFF));
   endtask

   task automatic test_fill_table();
      for (int i = 0; i < RLRA_MAX_RUNS; i++)
         send_item(make_write(i, 16'(i * 64 + $urandom_range(0, 63)), random_word(),
                              1'($urandom)));
   endtask

   task automatic test_directed();
      set_run_count(1);
      send_item(make_lookup(16'h0000));
      send_item(make_lookup(run_end_tbl[0]));
      send_item(make_lookup(run_end_tbl[0] + 16'd1));
      send_item(make_lookup(16'hFFFF));
      set_run_count(RLRA_MAX_RUNS);
      send_item(make_lookup(16'h0000));
      send_item(make_lookup(run_end_tbl[511]));
      send_item(make_lookup(run_end_tbl[1023]));
      send_item(make_lookup(16'hFFFF));
      send_item(make_write(1023, 16'hFFFF, {64{1'b1}}, 1'b1));
      send_item(make_lookup(16'hFFFF));
      send_item(make_write(0, 16'h0000, 64'd0, 1'b0));
      send_item(make_lookup(16'h0000));
      // too large: clamp to the table size
      set_run_count(2047);
      send_item(make_lookup(run_end_tbl[700]));
      // break the ascending order, then restore it
      send_item(make_write(3, 16'hFFFF, random_word(), 1'b0));
      send_item(make_lookup(run_end_tbl[4]));
      send_item(make_write(3, run_end_tbl[2] + 16'd1, random_word(), 1'b1));
      set_run_count(2);
      send_item(make_lookup(run_end_tbl[1]));
      send_item(make_lookup(run_end_tbl[1] + 16'd1));
   endtask

   task automatic random_write();
      int unsigned slot;
      logic [15:0] lo_end;
      logic [15:0] hi_end;
      slot = $urandom_range(0, RLRA_MAX_RUNS - 1);
      if ($urandom_range(0, 4) == 0) begin
         send_item(make_write(slot, 16'($urandom), random_word(), 1'($urandom)));
      end else begin
         lo_end = (slot == 0) ? 16'h0000 : run_end_tbl[slot - 1];
         hi_end = (slot == RLRA_MAX_RUNS - 1) ? 16'hFFFF : run_end_tbl[slot + 1];
         send_item(make_write(slot, 16'($urandom_range(hi_end, lo_end)), random_word(),
                              1'($urandom)));
      end
   endtask

   task automatic test_random();
      int unsigned runs;
      int          roll;
      for (int phase = 0; phase < 10; phase++) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) runs = 0;
         else if (roll == 1) runs = $urandom_range(1, 3);
         else if (roll == 2) runs = RLRA_MAX_RUNS;
         else if (roll == 3) runs = $urandom_range(RLRA_MAX_RUNS + 1, 2047);
         else runs = $urandom_range(1, RLRA_MAX_RUNS);
         set_run_count(runs);
         bursty = (phase % 4 != 1);
         repeat (80) begin
            if ($urandom_range(0, 9) < 7) send_item(make_lookup(pick_position()));
            else random_write();
         end
      end
      bursty = 1'b1;
   endtask

   task automatic test_backpressure();
      set_run_count(RLRA_MAX_RUNS);
      hold_request = 300;
      repeat (12) send_item(make_lookup(pick_position()));
      // pause the sender until every result is back
      wait_drain();
      repeat (12) send_item(make_lookup(pick_position()));
   endtask

   initial begin : main
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_fill_table();
      test_directed();
      test_random();
      test_backpressure();
      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_lookups.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
